// ----- rtl/evt_pkg.sv -----
// Shared types and codes for the election vote tally block.
// Used by evt_ctrl, evt_datapath and election_vote_tally_top; no dependencies.
package evt_pkg;

  localparam int MAX_VOTERS = 16;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 5;
  localparam int TERM_W     = 32;

  // opcodes
  localparam logic [1:0] OP_RAW_VOTE = 2'd0;
  localparam logic [1:0] OP_RESPONSE = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;

  // vote values of a raw vote
  localparam logic [1:0] VOTE_UNKNOWN = 2'd0;
  localparam logic [1:0] VOTE_GRANTED = 2'd1;
  localparam logic [1:0] VOTE_DENIED  = 2'd2;

  // vote store entries (vote value plus one, zero = no vote)
  localparam logic [1:0] STORE_NONE = 2'd0;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_CONFLICT  = 3'd2;
  localparam logic [2:0] ST_TOO_MANY  = 3'd3;
  localparam logic [2:0] ST_UNKNOWN   = 3'd4;
  localparam logic [2:0] ST_IGNORED   = 3'd5;

  // latched decision codes
  localparam logic [1:0] DEC_NONE = 2'd0;
  localparam logic [1:0] DEC_WON  = 2'd1;
  localparam logic [1:0] DEC_LOST = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_VOTERS      = 2'd0;
  localparam logic [1:0] CFG_QUORUM      = 2'd1;
  localparam logic [1:0] CFG_TERM        = 2'd2;
  localparam logic [1:0] CFG_PREELECTION = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic load;   // capture the input item
    logic exec;   // update the tally from the captured item
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [IDX_W-1:0]  voter_index;
    logic [1:0]        vote_value;
    logic              rpc_failed;
    logic              tablet_error;
    logic              id_mismatch;
    logic              peer_preelection;
    logic              vote_yes;
    logic [TERM_W-1:0] peer_term;
  } item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [1:0]        decision;
    logic              decided_now;
    logic              cancelled_by_term;
    logic [TERM_W-1:0] higher_term_seen;
    logic              preelection_unsupported;
    logic [CNT_W-1:0]  yes_count;
    logic [CNT_W-1:0]  no_count;
    logic              all_votes_in;
  } result_t;

endpackage

// ----- rtl/election_vote_tally_top.sv -----
// Top level of the election vote tally block.
// Instantiates evt_ctrl and evt_datapath; depends on evt_pkg.
//
// Vote tally for a leader election. An item is taken when start is high
// and busy is low; busy then stays high for one cycle while the tally is
// updated, so the block cannot take a new item while one is being updated
// (capture, then the single read-modify-write of the vote store and counters).
// The result of each item appears on the out_ ports for exactly one cycle with
// out_valid high: the cycle right after the busy cycle; a new item can be
// taken at the edge that ends it. The result is not held, and the receiver
// has no way to stall it, so it must sample out_valid every cycle. Every
// item, clear and ignored ones included, yields exactly one result.
// Configuration registers (0 voter count, 1 quorum size, 2 candidate term,
// 3 pre-election mode) are written through cfg_valid/cfg_ready, which is
// always ready; write them only while no item is in flight. The vote store
// is flip-flops cleared at once by reset or a clear item: no clearing pass.
module election_vote_tally_top (
  input  logic                       clk,
  input  logic                       rst_n,
  // item channel
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_opcode,
  input  logic [evt_pkg::IDX_W-1:0]  in_voter_index,
  input  logic [1:0]                 in_vote_value,
  input  logic                       in_rpc_failed,
  input  logic                       in_tablet_error,
  input  logic                       in_id_mismatch,
  input  logic                       in_peer_preelection,
  input  logic                       in_vote_yes,
  input  logic [evt_pkg::TERM_W-1:0] in_peer_term,
  // result channel
  output logic                       out_valid,
  output logic [2:0]                 out_status,
  output logic [1:0]                 out_decision,
  output logic                       out_decided_now,
  output logic                       out_cancelled_by_term,
  output logic [evt_pkg::TERM_W-1:0] out_higher_term_seen,
  output logic                       out_preelection_unsupported,
  output logic [evt_pkg::CNT_W-1:0]  out_yes_count,
  output logic [evt_pkg::CNT_W-1:0]  out_no_count,
  output logic                       out_all_votes_in,
  // configuration write channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [evt_pkg::TERM_W-1:0] cfg_data
);

  evt_pkg::dp_cmd_t cmd;
  evt_pkg::item_t   item;
  evt_pkg::result_t res;

  // config registers are plain flops, a write always lands
  assign cfg_ready = 1'b1;

  assign item.opcode           = in_opcode;
  assign item.voter_index      = in_voter_index;
  assign item.vote_value       = in_vote_value;
  assign item.rpc_failed       = in_rpc_failed;
  assign item.tablet_error     = in_tablet_error;
  assign item.id_mismatch      = in_id_mismatch;
  assign item.peer_preelection = in_peer_preelection;
  assign item.vote_yes         = in_vote_yes;
  assign item.peer_term        = in_peer_term;

  evt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  evt_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .item      (item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (out_valid),
    .res       (res)
  );

  assign out_status                  = res.status;
  assign out_decision                = res.decision;
  assign out_decided_now             = res.decided_now;
  assign out_cancelled_by_term       = res.cancelled_by_term;
  assign out_higher_term_seen        = res.higher_term_seen;
  assign out_preelection_unsupported = res.preelection_unsupported;
  assign out_yes_count               = res.yes_count;
  assign out_no_count                = res.no_count;
  assign out_all_votes_in            = res.all_votes_in;

endmodule

// ----- rtl/evt_ctrl.sv -----
// Controller of the election vote tally: two-state sequencer (capture, update).
// Depends on evt_pkg.
module evt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output evt_pkg::dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy     = (state_r == S_EXEC);
  assign cmd.load = start && (state_r == S_IDLE);
  assign cmd.exec = (state_r == S_EXEC);

  a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.exec)
    else $error("captured item not executed next cycle");

  a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> !busy)
    else $error("update phase lasted more than one cycle");

  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !cmd.load)
    else $error("item captured while busy");

endmodule

// ----- rtl/evt_datapath.sv -----
// Datapath of the election vote tally: config registers, vote store, counters,
// decision latch and the registered result. Depends on evt_pkg.
module evt_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  evt_pkg::dp_cmd_t             cmd,
  input  evt_pkg::item_t               item,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [evt_pkg::TERM_W-1:0]   cfg_data,
  output logic                         res_valid,
  output evt_pkg::result_t             res
);

  // configuration
  logic [evt_pkg::CNT_W-1:0]  voters_r;
  logic [evt_pkg::CNT_W-1:0]  majority_r;
  logic [evt_pkg::TERM_W-1:0] elect_term_r;
  logic                       pre_mode_r;

  // captured item
  evt_pkg::item_t it_r;

  // tally state
  logic [1:0]                 store_r   [evt_pkg::MAX_VOTERS];
  logic [1:0]                 store_nxt [evt_pkg::MAX_VOTERS];
  logic [evt_pkg::CNT_W-1:0]  granted_r, granted_nxt;
  logic [evt_pkg::CNT_W-1:0]  denied_r, denied_nxt;
  logic [1:0]                 latched_r, latched_nxt;
  logic                       responded_r, responded_nxt;
  logic [evt_pkg::TERM_W-1:0] cancel_term_r, cancel_term_nxt;
  logic                       cancel_r, cancel_nxt;

  logic                       res_valid_r;
  evt_pkg::result_t           res_r, res_nxt;

  logic                       do_vote;
  logic                       do_denial;
  logic [1:0]                 vcode;
  logic [1:0]                 venc;
  logic [1:0]                 cur;
  logic [2:0]                 status;
  logic                       unsup;
  logic [1:0]                 verdict;
  logic                       now;
  logic [evt_pkg::CNT_W:0]    votes_sum;
  logic [evt_pkg::CNT_W:0]    loss_lhs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      voters_r     <= evt_pkg::CNT_W'(1);
      majority_r   <= evt_pkg::CNT_W'(1);
      elect_term_r <= '0;
      pre_mode_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        evt_pkg::CFG_VOTERS:      voters_r     <= cfg_data[evt_pkg::CNT_W-1:0];
        evt_pkg::CFG_QUORUM:      majority_r   <= cfg_data[evt_pkg::CNT_W-1:0];
        evt_pkg::CFG_TERM:        elect_term_r <= cfg_data;
        evt_pkg::CFG_PREELECTION: pre_mode_r   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_r <= item;
    end
  end

  always_comb begin
    store_nxt       = store_r;
    granted_nxt     = granted_r;
    denied_nxt      = denied_r;
    latched_nxt     = latched_r;
    responded_nxt   = responded_r;
    cancel_term_nxt = cancel_term_r;
    cancel_nxt      = cancel_r;
    status          = evt_pkg::ST_OK;
    unsup           = 1'b0;
    do_vote         = 1'b0;
    do_denial       = 1'b0;
    vcode           = evt_pkg::VOTE_UNKNOWN;

    unique case (it_r.opcode)
      evt_pkg::OP_RAW_VOTE: begin
        do_vote = 1'b1;
        vcode   = (it_r.vote_value == 2'd3) ? evt_pkg::VOTE_UNKNOWN : it_r.vote_value;
      end
      evt_pkg::OP_RESPONSE: begin
        priority if (responded_r) begin
          status = evt_pkg::ST_IGNORED;
        end else if (it_r.rpc_failed || it_r.tablet_error || it_r.id_mismatch) begin
          do_vote = 1'b1;
          vcode   = evt_pkg::VOTE_DENIED;
        end else if (pre_mode_r && !it_r.peer_preelection) begin
          unsup     = 1'b1;
          do_denial = 1'b1;
        end else if (it_r.vote_yes) begin
          do_vote = 1'b1;
          vcode   = evt_pkg::VOTE_GRANTED;
        end else begin
          do_denial = 1'b1;
        end
      end
      evt_pkg::OP_CLEAR: begin
        store_nxt       = '{default: evt_pkg::STORE_NONE};
        granted_nxt     = '0;
        denied_nxt      = '0;
        latched_nxt     = evt_pkg::DEC_NONE;
        responded_nxt   = 1'b0;
        cancel_term_nxt = '0;
        cancel_nxt      = 1'b0;
      end
      default: begin
        status = evt_pkg::ST_IGNORED;
      end
    endcase

    // denial with a newer responder term cancels instead of voting
    if (do_denial) begin
      if (it_r.peer_term > elect_term_r) begin
        if (latched_r == evt_pkg::DEC_NONE) begin
          latched_nxt     = evt_pkg::DEC_LOST;
          cancel_term_nxt = it_r.peer_term;
          cancel_nxt      = 1'b1;
        end
      end else begin
        do_vote = 1'b1;
        vcode   = evt_pkg::VOTE_DENIED;
      end
    end

    venc      = vcode + 2'd1;
    cur       = store_r[it_r.voter_index];
    votes_sum = {1'b0, granted_r} + {1'b0, denied_r};
    if (do_vote) begin
      priority if (cur != evt_pkg::STORE_NONE) begin
        status = (cur == venc) ? evt_pkg::ST_DUPLICATE : evt_pkg::ST_CONFLICT;
      end else if (votes_sum >= {1'b0, voters_r}) begin
        status = evt_pkg::ST_TOO_MANY;
      end else begin
        store_nxt[it_r.voter_index] = venc;
        priority if (vcode == evt_pkg::VOTE_GRANTED) begin
          granted_nxt = granted_r + evt_pkg::CNT_W'(1);
        end else if (vcode == evt_pkg::VOTE_DENIED) begin
          denied_nxt = denied_r + evt_pkg::CNT_W'(1);
        end else begin
          status = evt_pkg::ST_UNKNOWN;
        end
      end
    end

    // win on majority; lose once denials exceed voters - quorum
    loss_lhs = {1'b0, denied_nxt} + {1'b0, majority_r};
    priority if (granted_nxt >= majority_r) begin
      verdict = evt_pkg::DEC_WON;
    end else if (loss_lhs > {1'b0, voters_r}) begin
      verdict = evt_pkg::DEC_LOST;
    end else begin
      verdict = evt_pkg::DEC_NONE;
    end
    if (latched_nxt == evt_pkg::DEC_NONE) begin
      latched_nxt = verdict;
    end
    now = 1'b0;
    if (latched_nxt != evt_pkg::DEC_NONE && !responded_nxt) begin
      responded_nxt = 1'b1;
      now           = 1'b1;
    end

    res_nxt.status                  = status;
    res_nxt.decision                = latched_nxt;
    res_nxt.decided_now             = now;
    res_nxt.cancelled_by_term       = cancel_nxt;
    res_nxt.higher_term_seen        = cancel_term_nxt;
    res_nxt.preelection_unsupported = unsup;
    res_nxt.yes_count               = granted_nxt;
    res_nxt.no_count                = denied_nxt;
    res_nxt.all_votes_in            =
      (({1'b0, granted_nxt} + {1'b0, denied_nxt}) == {1'b0, voters_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r       <= '{default: evt_pkg::STORE_NONE};
      granted_r     <= '0;
      denied_r      <= '0;
      latched_r     <= evt_pkg::DEC_NONE;
      responded_r   <= 1'b0;
      cancel_term_r <= '0;
      cancel_r      <= 1'b0;
      res_valid_r   <= 1'b0;
    end else begin
      res_valid_r <= cmd.exec;
      if (cmd.exec) begin
        store_r       <= store_nxt;
        granted_r     <= granted_nxt;
        denied_r      <= denied_nxt;
        latched_r     <= latched_nxt;
        responded_r   <= responded_nxt;
        cancel_term_r <= cancel_term_nxt;
        cancel_r      <= cancel_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

  a_valid_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r |-> $past(cmd.exec))
    else $error("result strobe without an update cycle");

  a_now_has_decision: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && res_r.decided_now) |-> (res_r.decision != evt_pkg::DEC_NONE))
    else $error("decided_now reported with no decision");

  a_cancel_is_loss: assert property (@(posedge clk) disable iff (!rst_n)
    cancel_r |-> (latched_r == evt_pkg::DEC_LOST))
    else $error("cancelled election not latched as lost");

  a_decision_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && it_r.opcode != evt_pkg::OP_CLEAR && latched_r != evt_pkg::DEC_NONE)
      |=> (latched_r == $past(latched_r)))
    else $error("latched decision changed without a clear");

endmodule

// ----- dv/evt_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for election_vote_tally_top: follows config writes and accepted items,
// predicts each result and compares it with the out_ channel. Depends on evt_pkg.
module evt_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  evt_pkg::item_t             item,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [evt_pkg::TERM_W-1:0] cfg_data,
  input  logic                       out_valid,
  input  evt_pkg::result_t           seen,
  output int                         fail_count,
  output int                         outstanding,
  output int                         counted_items
);

  // predicted tally state
  logic [1:0]                 ballot [evt_pkg::MAX_VOTERS];
  int                         yes_n;
  int                         no_n;
  logic [1:0]                 verdict_q;
  logic                       reported;
  logic                       cancelled;
  logic [evt_pkg::TERM_W-1:0] cancel_term_q;

  // shadow of the config registers
  logic [evt_pkg::CNT_W-1:0]  voters_cfg;
  logic [evt_pkg::CNT_W-1:0]  majority_cfg;
  logic [evt_pkg::TERM_W-1:0] term_cfg;
  logic                       pre_cfg;

  evt_pkg::result_t           tally_results_q [$];
  evt_pkg::result_t           want;
  int                         misses;

  function automatic void clear_tally();
    foreach (ballot[i]) ballot[i] = evt_pkg::STORE_NONE;
    yes_n         = 0;
    no_n          = 0;
    verdict_q     = evt_pkg::DEC_NONE;
    reported      = 1'b0;
    cancelled     = 1'b0;
    cancel_term_q = '0;
  endfunction

  // store entry is the vote value plus one
  function automatic logic [2:0] record_vote(input logic [evt_pkg::IDX_W-1:0] idx,
                                             input logic [1:0] code);
    logic [1:0] enc;
    enc = code + 2'd1;
    if (ballot[idx] != evt_pkg::STORE_NONE)
      return (ballot[idx] == enc) ? evt_pkg::ST_DUPLICATE : evt_pkg::ST_CONFLICT;
    if (yes_n + no_n >= int'(voters_cfg)) return evt_pkg::ST_TOO_MANY;
    ballot[idx] = enc;
    if (code == evt_pkg::VOTE_GRANTED) begin
      yes_n++;
      return evt_pkg::ST_OK;
    end
    if (code == evt_pkg::VOTE_DENIED) begin
      no_n++;
      return evt_pkg::ST_OK;
    end
    return evt_pkg::ST_UNKNOWN;
  endfunction

  // a denial from a higher term cancels instead of counting
  function automatic logic [2:0] deny_vote(input logic [evt_pkg::IDX_W-1:0] idx,
                                           input logic [evt_pkg::TERM_W-1:0] term);
    if (term > term_cfg) begin
      if (verdict_q == evt_pkg::DEC_NONE) begin
        verdict_q     = evt_pkg::DEC_LOST;
        cancel_term_q = term;
        cancelled     = 1'b1;
      end
      return evt_pkg::ST_OK;
    end
    return record_vote(idx, evt_pkg::VOTE_DENIED);
  endfunction

  function automatic evt_pkg::result_t tally_step(input evt_pkg::item_t it);
    evt_pkg::result_t r;
    logic [1:0]       vv;
    logic [1:0]       outcome;
    r       = '0;
    outcome = evt_pkg::DEC_NONE;
    case (it.opcode)
      evt_pkg::OP_RAW_VOTE: begin
        vv = (it.vote_value > evt_pkg::VOTE_DENIED) ? evt_pkg::VOTE_UNKNOWN : it.vote_value;
        r.status = record_vote(it.voter_index, vv);
      end
      evt_pkg::OP_RESPONSE: begin
        if (reported) begin
          r.status = evt_pkg::ST_IGNORED;
        end else if (it.rpc_failed || it.tablet_error || it.id_mismatch) begin
          r.status = record_vote(it.voter_index, evt_pkg::VOTE_DENIED);
        end else if (pre_cfg && !it.peer_preelection) begin
          r.preelection_unsupported = 1'b1;
          r.status = deny_vote(it.voter_index, it.peer_term);
        end else if (it.vote_yes) begin
          r.status = record_vote(it.voter_index, evt_pkg::VOTE_GRANTED);
        end else begin
          r.status = deny_vote(it.voter_index, it.peer_term);
        end
      end
      evt_pkg::OP_CLEAR: clear_tally();
      default: r.status = evt_pkg::ST_IGNORED;
    endcase

    // loss threshold is signed: majority above voter count loses at once
    if (yes_n >= int'(majority_cfg)) outcome = evt_pkg::DEC_WON;
    else if (no_n > int'(voters_cfg) - int'(majority_cfg)) outcome = evt_pkg::DEC_LOST;
    if (verdict_q == evt_pkg::DEC_NONE) verdict_q = outcome;
    if (verdict_q != evt_pkg::DEC_NONE && !reported) begin
      reported      = 1'b1;
      r.decided_now = 1'b1;
    end

    r.decision          = verdict_q;
    r.cancelled_by_term = cancelled;
    r.higher_term_seen  = cancel_term_q;
    r.yes_count         = evt_pkg::CNT_W'(yes_n);
    r.no_count          = evt_pkg::CNT_W'(no_n);
    r.all_votes_in      = (yes_n + no_n == int'(voters_cfg));
    return r;
  endfunction

  function automatic int field_miss(input string name, input logic [31:0] exp_v,
                                    input logic [31:0] act_v);
    if (act_v === exp_v) return 0;
    $error("%s: expected %0d, got %0d", name, exp_v, act_v);
    return 1;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      voters_cfg    = 5'd1;
      majority_cfg  = 5'd1;
      term_cfg      = '0;
      pre_cfg       = 1'b0;
      clear_tally();
      tally_results_q.delete();
      fail_count    = 0;
      counted_items = 0;
    end else begin
      if (out_valid) begin
        if (tally_results_q.size() == 0) begin
          $error("result with no item pending: status %0d", seen.status);
          fail_count++;
        end else begin
          want   = tally_results_q.pop_front();
          misses = field_miss("status", 32'(want.status), 32'(seen.status))
                 + field_miss("decision", 32'(want.decision), 32'(seen.decision))
                 + field_miss("decided_now", 32'(want.decided_now),
                              32'(seen.decided_now))
                 + field_miss("cancelled_by_term", 32'(want.cancelled_by_term),
                              32'(seen.cancelled_by_term))
                 + field_miss("higher_term_seen", 32'(want.higher_term_seen),
                              32'(seen.higher_term_seen))
                 + field_miss("preelection_unsupported",
                              32'(want.preelection_unsupported),
                              32'(seen.preelection_unsupported))
                 + field_miss("yes_count", 32'(want.yes_count), 32'(seen.yes_count))
                 + field_miss("no_count", 32'(want.no_count), 32'(seen.no_count))
                 + field_miss("all_votes_in", 32'(want.all_votes_in),
                              32'(seen.all_votes_in));
          fail_count += misses;
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          evt_pkg::CFG_VOTERS:      voters_cfg   = cfg_data[evt_pkg::CNT_W-1:0];
          evt_pkg::CFG_QUORUM:      majority_cfg = cfg_data[evt_pkg::CNT_W-1:0];
          evt_pkg::CFG_TERM:        term_cfg     = cfg_data;
          evt_pkg::CFG_PREELECTION: pre_cfg      = cfg_data[0];
          default: ;
        endcase
      end

      if (start && !busy) begin
        want = tally_step(item);
        tally_results_q = {tally_results_q, want};
        counted_items++;
      end
    end
    outstanding = tally_results_q.size();
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench top for election_vote_tally_top: drives items and config writes,
// gives the verdict. Depends on evt_pkg and evt_checker.
module tb_top;

  // codes outside the documented range, still defined by the block
  localparam logic [1:0] OP_SPARE   = 2'd3;
  localparam logic [1:0] VOTE_SPARE = 2'd3;

  // accepted items to push through the run
  localparam int ITEM_TARGET = 1750;
  localparam int MAX_GAP     = 40;

  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       start     = 1'b0;
  logic                       cfg_valid = 1'b0;
  logic [1:0]                 cfg_index = evt_pkg::CFG_VOTERS;
  logic [evt_pkg::TERM_W-1:0] cfg_data  = '0;
  evt_pkg::item_t             drv       = '0;

  logic                       busy;
  logic                       cfg_ready;
  logic                       out_valid;
  logic [2:0]                 out_status;
  logic [1:0]                 out_decision;
  logic                       out_decided_now;
  logic                       out_cancelled_by_term;
  logic [evt_pkg::TERM_W-1:0] out_higher_term_seen;
  logic                       out_preelection_unsupported;
  logic [evt_pkg::CNT_W-1:0]  out_yes_count;
  logic [evt_pkg::CNT_W-1:0]  out_no_count;
  logic                       out_all_votes_in;
  evt_pkg::result_t           seen;

  int                         fails;
  int                         outstanding;
  int                         counted;

  // handshake flags, sampled at the rising edge and read at the falling one
  logic                       took_item = 1'b0;
  logic                       took_cfg  = 1'b0;

  // sender idle chance per cycle, in percent
  int                         idle_pct = 0;

  // current config, used only to shape the stimulus
  logic [evt_pkg::CNT_W-1:0]  voters_now = 5'd1;
  logic [evt_pkg::TERM_W-1:0] term_now   = '0;

  always #10 clk = ~clk;

  always @(posedge clk) begin
    took_item <= start && !busy;
    took_cfg  <= cfg_valid && cfg_ready;
  end

  election_vote_tally_top uut (
    .clk                         (clk),
    .rst_n                       (rst_n),
    .start                       (start),
    .busy                        (busy),
    .in_opcode                   (drv.opcode),
    .in_voter_index              (drv.voter_index),
    .in_vote_value               (drv.vote_value),
    .in_rpc_failed               (drv.rpc_failed),
    .in_tablet_error             (drv.tablet_error),
    .in_id_mismatch              (drv.id_mismatch),
    .in_peer_preelection         (drv.peer_preelection),
    .in_vote_yes                 (drv.vote_yes),
    .in_peer_term                (drv.peer_term),
    .out_valid                   (out_valid),
    .out_status                  (out_status),
    .out_decision                (out_decision),
    .out_decided_now             (out_decided_now),
    .out_cancelled_by_term       (out_cancelled_by_term),
    .out_higher_term_seen        (out_higher_term_seen),
    .out_preelection_unsupported (out_preelection_unsupported),
    .out_yes_count               (out_yes_count),
    .out_no_count                (out_no_count),
    .out_all_votes_in            (out_all_votes_in),
    .cfg_valid                   (cfg_valid),
    .cfg_ready                   (cfg_ready),
    .cfg_index                   (cfg_index),
    .cfg_data                    (cfg_data)
  );

  // packed in result_t field order
  assign seen = {out_status, out_decision, out_decided_now, out_cancelled_by_term,
                 out_higher_term_seen, out_preelection_unsupported, out_yes_count,
                 out_no_count, out_all_votes_in};

  evt_checker tally_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .item          (drv),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .seen          (seen),
    .fail_count    (fails),
    .outstanding   (outstanding),
    .counted_items (counted)
  );

  // Item builders. Fields the opcode does not use carry random noise.
  function automatic evt_pkg::item_t noise_item();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(evt_pkg::item_t)-1:0];
  endfunction

  function automatic evt_pkg::item_t raw_vote(input logic [evt_pkg::IDX_W-1:0] idx,
                                              input logic [1:0] vv);
    evt_pkg::item_t it;
    it             = noise_item();
    it.opcode      = evt_pkg::OP_RAW_VOTE;
    it.voter_index = idx;
    it.vote_value  = vv;
    return it;
  endfunction

  function automatic evt_pkg::item_t peer_reply(input logic [evt_pkg::IDX_W-1:0] idx,
                                                input logic rpc, input logic tab,
                                                input logic idm, input logic pre,
                                                input logic grant,
                                                input logic [evt_pkg::TERM_W-1:0] term);
    evt_pkg::item_t it;
    it                  = noise_item();
    it.opcode           = evt_pkg::OP_RESPONSE;
    it.voter_index      = idx;
    it.rpc_failed       = rpc;
    it.tablet_error     = tab;
    it.id_mismatch      = idm;
    it.peer_preelection = pre;
    it.vote_yes         = grant;
    it.peer_term        = term;
    return it;
  endfunction

  function automatic evt_pkg::item_t bare_op(input logic [1:0] op);
    evt_pkg::item_t it;
    it        = noise_item();
    it.opcode = op;
    return it;
  endfunction

  // Mostly well-formed votes and responses; a few clears and spare opcodes.
  function automatic evt_pkg::item_t random_item();
    evt_pkg::item_t             it;
    int                         pick;
    logic [63:0]                r;
    logic [evt_pkg::TERM_W-1:0] term;
    logic [1:0]                 vv;
    pick = $urandom_range(99);
    if (pick < 3) return bare_op(OP_SPARE);
    if (pick < 5) return bare_op(evt_pkg::OP_CLEAR);
    if (pick < 45) begin
      pick = $urandom_range(99);
      if (pick < 45)      vv = evt_pkg::VOTE_GRANTED;
      else if (pick < 85) vv = evt_pkg::VOTE_DENIED;
      else if (pick < 95) vv = evt_pkg::VOTE_UNKNOWN;
      else                vv = VOTE_SPARE;
      return raw_vote(4'($urandom_range(evt_pkg::MAX_VOTERS - 1)), vv);
    end
    // responder term: usually at or below ours, sometimes above
    pick = $urandom_range(19);
    r    = {$urandom, $urandom};
    if (pick < 2)       term = $urandom;
    else if (pick == 2) term = (term_now == '1) ? term_now : term_now + 32'd1;
    else                term = evt_pkg::TERM_W'(r % (64'(term_now) + 64'd1));
    it = peer_reply(4'($urandom_range(evt_pkg::MAX_VOTERS - 1)),
                    $urandom_range(99) < 8, $urandom_range(99) < 8,
                    $urandom_range(99) < 8, $urandom_range(99) < 85,
                    $urandom_range(99) < 60, term);
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  // start stays high so back-to-back items need no extra edge.
  task automatic issue(input evt_pkg::item_t it);
    int gap;
    gap = 0;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct && gap < MAX_GAP) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    drv   <= it;
    start <= 1'b1;
    do @(negedge clk); while (!took_item);
  endtask

  // Drop start and wait until every expected result has come back.
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (4) @(negedge clk);
  endtask

  // All four registers, back to back, only while the block is idle.
  task automatic program_election(input logic [evt_pkg::CNT_W-1:0] n,
                                  input logic [evt_pkg::CNT_W-1:0] maj,
                                  input logic [evt_pkg::TERM_W-1:0] term,
                                  input logic pre);
    logic [1:0]                 reg_idx [4];
    logic [evt_pkg::TERM_W-1:0] reg_val [4];
    reg_idx = '{evt_pkg::CFG_VOTERS, evt_pkg::CFG_QUORUM, evt_pkg::CFG_TERM,
                evt_pkg::CFG_PREELECTION};
    reg_val = '{evt_pkg::TERM_W'(n), evt_pkg::TERM_W'(maj), term, evt_pkg::TERM_W'(pre)};
    settle();
    for (int k = 0; k < 4; k++) begin
      cfg_index <= reg_idx[k];
      cfg_data  <= reg_val[k];
      cfg_valid <= 1'b1;
      do @(negedge clk); while (!took_cfg);
    end
    cfg_valid  <= 1'b0;
    voters_now = n;
    term_now   = term;
  endtask

  initial begin
    int                         round;
    int                         elections;
    logic [evt_pkg::CNT_W-1:0]  n;
    logic [evt_pkg::CNT_W-1:0]  maj;
    logic [evt_pkg::TERM_W-1:0] term;
    logic                       pre;
    int                         phase_pct [4];
    phase_pct = '{0, 45, 31, 0};
    round     = 0;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed: 16 voters, majority 9, term 100, pre-election round ---
    program_election(5'd16, 5'd9, 32'd100, 1'b1);
    issue(bare_op(evt_pkg::OP_CLEAR));
    issue(raw_vote(4'd0, evt_pkg::VOTE_GRANTED));
    issue(raw_vote(4'd0, evt_pkg::VOTE_GRANTED));  // same voter, same vote
    issue(raw_vote(4'd0, evt_pkg::VOTE_DENIED));   // same voter, other vote
    issue(raw_vote(4'd15, evt_pkg::VOTE_UNKNOWN)); // stored, not counted
    issue(raw_vote(4'd14, VOTE_SPARE));            // spare value reads as unknown
    issue(peer_reply(4'd1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 32'd0));   // transport failure
    issue(peer_reply(4'd2, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 32'd0));   // tablet error
    issue(peer_reply(4'd3, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 32'd0));   // wrong responder
    issue(peer_reply(4'd4, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 32'd50));  // no pre-election
    issue(peer_reply(4'd5, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, '1));      // grant, huge term
    issue(peer_reply(4'd6, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 32'd100)); // deny, equal term
    issue(bare_op(OP_SPARE));
    issue(peer_reply(4'd7, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, '1));      // higher term cancels
    issue(peer_reply(4'd8, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 32'd0));   // after decision
    issue(raw_vote(4'd9, evt_pkg::VOTE_GRANTED));  // still recorded once decided

    // zero majority wins on the clear; third vote overflows two voters
    program_election(5'd2, 5'd0, 32'd0, 1'b0);
    issue(bare_op(evt_pkg::OP_CLEAR));
    issue(raw_vote(4'd0, evt_pkg::VOTE_DENIED));
    issue(raw_vote(4'd1, evt_pkg::VOTE_GRANTED));
    issue(raw_vote(4'd2, evt_pkg::VOTE_GRANTED));
    issue(peer_reply(4'd3, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 32'd0));

    // majority above voter count loses on the clear
    program_election(5'd1, 5'd16, 32'hFFFF_FFFE, 1'b1);
    issue(bare_op(evt_pkg::OP_CLEAR));

    // missing pre-election support with a higher term cancels despite a grant
    program_election(5'd4, 5'd3, 32'd10, 1'b1);
    issue(bare_op(evt_pkg::OP_CLEAR));
    issue(peer_reply(4'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 32'd11));

    // --- random: rounds of config, each with a few elections ---
    while (counted < ITEM_TARGET) begin
      case (round)
        0: begin
          n = 5'd16; maj = 5'd16; term = '1; pre = 1'b1;
        end
        1: begin
          n = 5'd1; maj = 5'd0; term = '0; pre = 1'b0;
        end
        default: begin
          case ($urandom_range(9))
            0:       n = 5'd1;
            1:       n = 5'd16;
            default: n = 5'($urandom_range(1, evt_pkg::MAX_VOTERS));
          endcase
          case ($urandom_range(9))
            0:       maj = 5'd0;
            1:       maj = n;
            2:       maj = 5'($urandom_range(1, evt_pkg::MAX_VOTERS));
            3:       maj = 5'd1;
            default: maj = (n >> 1) + 5'd1;
          endcase
          case ($urandom_range(7))
            0:       term = '0;
            1:       term = '1;
            2:       term = 32'($urandom_range(1000));
            default: term = $urandom;
          endcase
          pre = 1'($urandom_range(1));
        end
      endcase
      program_election(n, maj, term, pre);

      // sender idling: none, heavy, moderate, none again
      idle_pct  = phase_pct[round % 4];
      elections = $urandom_range(2, 5);
      repeat (elections) begin
        issue(bare_op(evt_pkg::OP_CLEAR));
        repeat (int'(voters_now) + $urandom_range(0, 6)) issue(random_item());
      end
      round++;
    end

    // drain, then verdict
    settle();
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog: far beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/evt_pkg.sv
rtl/evt_ctrl.sv
rtl/evt_datapath.sv
rtl/election_vote_tally_top.sv
dv/evt_checker.sv
dv/tb_top.sv
